// ===== rtl/rdas_pkg.sv =====
package rdas_pkg;

    localparam int RESOLUTION_DEF = 384;

    localparam int TIME_W  = 32;
    localparam int ANGLE_W = 32;
    localparam int ARM_W   = 11;
    localparam int ORIG_W  = 9;
    localparam int CLK_W   = 8;
    localparam int PROD_W  = CLK_W + TIME_W;
    localparam int DIV_W   = 12;
    localparam int REM_SHIFT = ORIG_W + DIV_W;
    localparam int RECIP_W   = REM_SHIFT + 1;

    localparam logic [ORIG_W-1:0] ORIGIN_RST   = '0;
    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 32'd20000;
    localparam logic [CLK_W-1:0]  CLOCKS_RST   = 8'd80;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PULSE = 2'd1,
        OP_FRAME = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_ORIGIN   = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_CLOCKS   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic             fetch_valid;
        logic             bank;
        logic [ARM_W-1:0] arm_one_word;
        logic [ARM_W-1:0] arm_two_word;
        logic [ARM_W-1:0] arm_three_word;
        logic             reload_valid;
        logic             frame_released;
    } evt_flags_t;

    // remainder of a 9-bit value by a constant divisor through its scaled reciprocal
    // m is ceil(2^REM_SHIFT / d), exact for every 9-bit value and divisor below 4096
    function automatic logic [DIV_W-1:0] rem_of_origin(input logic [ORIG_W-1:0]  v,
                                                       input logic [DIV_W-1:0]   d,
                                                       input logic [RECIP_W-1:0] m);
        logic [ORIG_W+RECIP_W-1:0] p;
        logic [ORIG_W-1:0]         q;
        logic [ORIG_W+DIV_W-1:0]   qd;
        p  = (ORIG_W+RECIP_W)'(v) * (ORIG_W+RECIP_W)'(m);
        q  = ORIG_W'(p >> REM_SHIFT);
        qd = (ORIG_W+DIV_W)'(q) * (ORIG_W+DIV_W)'(d);
        return DIV_W'((ORIG_W+DIV_W)'(v) - qd);
    endfunction

endpackage

// ===== rtl/rotary_display_angle_sequencer_unit.sv =====
// Angle sequencer for a three-arm persistence-of-vision display. Events come in on the
// slave stream (tuser = operation, tdata = microsecond time stamp) and every event gives
// exactly one result word on the master stream. The block takes one event per clock
// unless the master stream stalls; s0, s1 and s2 lead to the output register, a depth
// set by the reload path, where clocks_per_us * period / RESOLUTION is done as a
// multiply by a constant reciprocal split into four partial products over two stages.
// The sequencer state (angle, bank, pending frame, pulse time stamps) is updated in the
// first stage, so back-to-back events always see the state left by the one before.
// Configuration (origin_angle at 0x0, debounce_us at 0x4, clocks_per_us at 0x8) must
// be written over the APB port while no event is in flight, unchecked by the block.
module rotary_display_angle_sequencer_unit
    import rdas_pkg::*;
#(
    parameter int RESOLUTION = RESOLUTION_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_us
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] fetch_valid, [1] bank, [12:2] arm_one_word, [23:13] arm_two_word,
    // [34:24] arm_three_word, [35] reload_valid, [67:36] reload_value,
    // [68] frame_released, [71:69] zero
    output logic [71:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(RESOLUTION);
    localparam int THIRD  = RESOLUTION / 3;
    localparam int TWO3   = (RESOLUTION * 2) / 3;
    localparam int PW     = (THIRD > 1) ? $clog2(THIRD) : 1;
    localparam int RSHIFT = PROD_W + AW;
    localparam int SUM_W  = 82;
    localparam logic [41:0] RECIP =
        42'(((64'd1 << RSHIFT) + 64'(RESOLUTION) - 64'd1) / 64'(RESOLUTION));
    localparam logic [RECIP_W-1:0] RECIP_RES =
        RECIP_W'(((1 << REM_SHIFT) + RESOLUTION - 1) / RESOLUTION);
    localparam logic [RECIP_W-1:0] RECIP_THIRD =
        RECIP_W'(((1 << REM_SHIFT) + THIRD - 1) / THIRD);

    // configuration
    logic [ORIG_W-1:0] origin_angle_reg;
    logic [TIME_W-1:0] debounce_us_reg;
    logic [CLK_W-1:0]  clocks_per_us_reg;
    logic [AW-1:0]     origin_mod_r_reg;
    logic [PW-1:0]     origin_mod_k_reg;

    // sequencer state
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [PW-1:0]      phase_reg, phase_next;
    logic               bank_reg, bank_next;
    logic               pending_reg, pending_next;
    logic [TIME_W-1:0]  accepted_time_reg, accepted_time_next;
    logic [TIME_W-1:0]  previous_time_reg, previous_time_next;

    // pipeline
    logic              s0_valid_reg;
    logic [1:0]        s0_op_reg;
    logic [TIME_W-1:0] s0_time_reg;
    logic              s1_valid_reg;
    evt_flags_t        s1_flags_reg, s1_flags_next;
    logic [PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic              s2_valid_reg;
    evt_flags_t        s2_flags_reg;
    logic [40:0]       s2_ll_reg, s2_lh_reg, s2_hl_reg, s2_hh_reg;
    logic              out_valid_reg;
    evt_flags_t        out_flags_reg;
    logic [31:0]       out_reload_reg, out_reload_next;

    logic ready_out, ready2, ready1, ready0;
    logic s1_load;

    logic              cfg_write;
    logic [1:0]        cfg_index;

    // per-event combinational signals
    logic [ANGLE_W-1:0] angle_inc;
    logic [PW-1:0]      phase_inc;
    logic [TIME_W-1:0]  since_previous;
    logic [TIME_W-1:0]  period;
    logic               fetch;
    logic [AW-1:0]      addr_angle;
    logic [AW:0]        sum_one, sum_two;
    logic [AW-1:0]      am_one, am_two;

    logic [SUM_W-1:0]   full_sum;
    logic [SUM_W-1:0]   quotient;

    assign ready_out = !out_valid_reg || m_axis_tready;
    assign ready2    = !s2_valid_reg || ready_out;
    assign ready1    = !s1_valid_reg || ready2;
    assign ready0    = !s0_valid_reg || ready1;
    assign s1_load   = s0_valid_reg && ready1;

    assign s_axis_tready = ready0;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_flags_reg.frame_released, out_reload_reg,
                            out_flags_reg.reload_valid, out_flags_reg.arm_three_word,
                            out_flags_reg.arm_two_word, out_flags_reg.arm_one_word,
                            out_flags_reg.bank, out_flags_reg.fetch_valid};

    // configuration port
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_index_t'(cfg_index))
            REG_ORIGIN:   prdata = 32'(origin_angle_reg);
            REG_DEBOUNCE: prdata = debounce_us_reg;
            REG_CLOCKS:   prdata = 32'(clocks_per_us_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_angle_reg  <= ORIGIN_RST;
            debounce_us_reg   <= DEBOUNCE_RST;
            clocks_per_us_reg <= CLOCKS_RST;
            origin_mod_r_reg  <= '0;
            origin_mod_k_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ORIGIN:
                begin
                    origin_angle_reg <= pwdata[ORIG_W-1:0];
                    origin_mod_r_reg <= AW'(rem_of_origin(pwdata[ORIG_W-1:0],
                                                          DIV_W'(RESOLUTION), RECIP_RES));
                    origin_mod_k_reg <= PW'(rem_of_origin(pwdata[ORIG_W-1:0],
                                                          DIV_W'(THIRD), RECIP_THIRD));
                end
                REG_DEBOUNCE: debounce_us_reg   <= pwdata;
                REG_CLOCKS:   clocks_per_us_reg <= pwdata[CLK_W-1:0];
                default:      ;
            endcase
        end
    end

    // first stage: state update and result flags
    assign angle_inc      = angle_reg + 1'b1;
    assign since_previous = s0_time_reg - previous_time_reg;
    assign period         = s0_time_reg - accepted_time_reg;

    // phase tracks angle mod RESOLUTION/3; the 32-bit wrap lands on a multiple too
    always_comb
    begin
        if (angle_inc == '0 || phase_reg == PW'(THIRD - 1))
        begin
            phase_inc = '0;
        end
        else
        begin
            phase_inc = phase_reg + 1'b1;
        end
    end

    always_comb
    begin
        angle_next         = angle_reg;
        phase_next         = phase_reg;
        bank_next          = bank_reg;
        pending_next       = pending_reg;
        accepted_time_next = accepted_time_reg;
        previous_time_next = previous_time_reg;
        s1_flags_next      = '0;
        s1_prod_next       = '0;
        fetch              = 1'b0;
        addr_angle         = '0;

        unique case (op_t'(s0_op_reg))
            OP_TICK:
            begin
                angle_next = angle_inc;
                phase_next = phase_inc;
                if (pending_reg && phase_inc == '0)
                begin
                    bank_next                    = !bank_reg;
                    pending_next                 = 1'b0;
                    s1_flags_next.frame_released = 1'b1;
                end
                if (angle_inc < ANGLE_W'(RESOLUTION))
                begin
                    fetch      = 1'b1;
                    addr_angle = angle_inc[AW-1:0];
                end
            end
            OP_PULSE:
            begin
                previous_time_next = s0_time_reg;
                if (since_previous > debounce_us_reg)
                begin
                    s1_flags_next.reload_valid = 1'b1;
                    s1_prod_next       = PROD_W'(clocks_per_us_reg) * PROD_W'(period);
                    angle_next         = ANGLE_W'(origin_angle_reg);
                    phase_next         = origin_mod_k_reg;
                    accepted_time_next = s0_time_reg;
                    if (pending_reg)
                    begin
                        bank_next                    = !bank_reg;
                        pending_next                 = 1'b0;
                        s1_flags_next.frame_released = 1'b1;
                    end
                    fetch      = 1'b1;
                    addr_angle = origin_mod_r_reg;
                end
            end
            OP_FRAME:
            begin
                pending_next = 1'b1;
            end
            default: ;
        endcase

        s1_flags_next.bank = bank_next;
        if (fetch)
        begin
            s1_flags_next.fetch_valid    = 1'b1;
            s1_flags_next.arm_one_word   = ARM_W'(am_one) << 2;
            s1_flags_next.arm_two_word   = ARM_W'(am_two) << 2;
            s1_flags_next.arm_three_word = ARM_W'(addr_angle) << 2;
        end
    end

    // arm slots: angle below RESOLUTION, so one compare and subtract wraps them
    assign sum_one = {1'b0, addr_angle} + (AW+1)'(THIRD);
    assign sum_two = {1'b0, addr_angle} + (AW+1)'(TWO3);
    assign am_one  = (sum_one >= (AW+1)'(RESOLUTION)) ?
                     AW'(sum_one - (AW+1)'(RESOLUTION)) : AW'(sum_one);
    assign am_two  = (sum_two >= (AW+1)'(RESOLUTION)) ?
                     AW'(sum_two - (AW+1)'(RESOLUTION)) : AW'(sum_two);

    // last stage: sum partial products, scale by the reciprocal shift, saturate
    assign full_sum = SUM_W'(s2_ll_reg) + (SUM_W'(s2_lh_reg) << 21)
                    + (SUM_W'(s2_hl_reg) << 20) + (SUM_W'(s2_hh_reg) << 41);
    assign quotient = full_sum >> RSHIFT;
    assign out_reload_next = (|quotient[SUM_W-1:32]) ? '1 : quotient[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg         <= '0;
            phase_reg         <= '0;
            bank_reg          <= 1'b0;
            pending_reg       <= 1'b0;
            accepted_time_reg <= '0;
            previous_time_reg <= '0;
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                s0_valid_reg <= s_axis_tvalid;
            end
            if (ready1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_load)
            begin
                angle_reg         <= angle_next;
                phase_reg         <= phase_next;
                bank_reg          <= bank_next;
                pending_reg       <= pending_next;
                accepted_time_reg <= accepted_time_next;
                previous_time_reg <= previous_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && s_axis_tvalid)
        begin
            s0_op_reg   <= s_axis_tuser;
            s0_time_reg <= s_axis_tdata;
        end
        if (s1_load)
        begin
            s1_flags_reg <= s1_flags_next;
            s1_prod_reg  <= s1_prod_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_ll_reg    <= 41'(s1_prod_reg[19:0])  * 41'(RECIP[20:0]);
            s2_lh_reg    <= 41'(s1_prod_reg[19:0])  * 41'(RECIP[41:21]);
            s2_hl_reg    <= 41'(s1_prod_reg[39:20]) * 41'(RECIP[20:0]);
            s2_hh_reg    <= 41'(s1_prod_reg[39:20]) * 41'(RECIP[41:21]);
        end
        if (ready_out && s2_valid_reg)
        begin
            out_flags_reg  <= s2_flags_reg;
            out_reload_reg <= out_reload_next;
        end
    end

`ifndef SYNTHESIS
    // phase must stay below RESOLUTION/3 for the bank swap test to be right
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PW'(THIRD - 1))
        else $error("angle phase out of range");

    a_origin_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (AW+1)'(origin_mod_r_reg) < (AW+1)'(RESOLUTION))
        else $error("wrapped origin slot out of range");

    // a release clears the pending frame and flips the shown bank
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load && s1_flags_next.frame_released
        |=> !pending_reg && bank_reg != $past(bank_reg))
        else $error("frame release did not swap banks");

    a_no_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_flags_reg.fetch_valid
        |-> out_flags_reg.arm_one_word == '0 && out_flags_reg.arm_two_word == '0
            && out_flags_reg.arm_three_word == '0)
        else $error("arm words set without fetch");

    a_no_reload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_flags_reg.reload_valid |-> out_reload_reg == '0)
        else $error("reload value set without reload");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
    import rdas_pkg::*;

    localparam int unsigned SLOTS = RESOLUTION_DEF;
    localparam int unsigned THIRD = SLOTS / 3;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        bit          fetch_valid;
        bit          bank;
        bit [10:0]   arm_one_word;
        bit [10:0]   arm_two_word;
        bit [10:0]   arm_three_word;
        bit          reload_valid;
        bit [31:0]   reload_value;
        bit          frame_released;
    } event_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // sequencer shadow: configuration and state
    logic [8:0]  cfg_origin = ORIGIN_RST;
    logic [31:0] cfg_debounce = DEBOUNCE_RST;
    logic [7:0]  cfg_clocks = CLOCKS_RST;
    logic [31:0] seq_angle = '0;
    logic        seq_bank = 1'b0;
    logic        frame_waiting = 1'b0;
    logic [31:0] accepted_time = '0;
    logic [31:0] last_pulse_time = '0;

    event_result_t pending_results[$];
    int mismatch_count = 0;
    int results_seen = 0;
    int sender_idle_pct = 18;
    int receiver_idle_pct = 88;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    rotary_display_angle_sequencer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [10:0] slot_word(input logic [31:0] a, input int unsigned shift);
        return 11'((((a % SLOTS) + shift) % SLOTS) * 4);
    endfunction

    function automatic void point_arms(inout event_result_t r, input logic [31:0] a);
        r.fetch_valid    = 1'b1;
        r.arm_one_word   = slot_word(a, THIRD);
        r.arm_two_word   = slot_word(a, 2 * THIRD);
        r.arm_three_word = slot_word(a, 0);
    endfunction

    function automatic event_result_t compute_event_result(input logic [1:0] op,
                                                           input logic [31:0] stamp);
        event_result_t r;
        logic [31:0]   elapsed;
        logic [39:0]   product;
        r = '{default: 0};
        case (op)
            OP_TICK:
            begin
                seq_angle = seq_angle + 32'd1;
                if (frame_waiting && (seq_angle % THIRD) == 0)
                begin
                    seq_bank         = ~seq_bank;
                    frame_waiting    = 1'b0;
                    r.frame_released = 1'b1;
                end
                if (seq_angle < SLOTS)
                begin
                    point_arms(r, seq_angle);
                end
            end
            OP_PULSE:
            begin
                // debounce against the previous pulse, counted or not
                if (32'(stamp - last_pulse_time) > cfg_debounce)
                begin
                    elapsed = stamp - accepted_time;
                    product = ({32'b0, cfg_clocks} * {8'b0, elapsed}) / SLOTS;
                    r.reload_valid = 1'b1;
                    r.reload_value = (product > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : product[31:0];
                    seq_angle = {23'b0, cfg_origin};
                    if (frame_waiting)
                    begin
                        seq_bank         = ~seq_bank;
                        frame_waiting    = 1'b0;
                        r.frame_released = 1'b1;
                    end
                    point_arms(r, seq_angle);
                    accepted_time = stamp;
                end
                last_pulse_time = stamp;
            end
            OP_FRAME:
            begin
                frame_waiting = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.bank = seq_bank;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("mismatch at result %0d: %s", results_seen, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        event_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transaction with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("fetch_valid", m_axis_tdata[0], want.fetch_valid);
                check_field("bank", m_axis_tdata[1], want.bank);
                check_field("arm_one_word", m_axis_tdata[12:2], want.arm_one_word);
                check_field("arm_two_word", m_axis_tdata[23:13], want.arm_two_word);
                check_field("arm_three_word", m_axis_tdata[34:24], want.arm_three_word);
                check_field("reload_valid", m_axis_tdata[35], want.reload_valid);
                check_field("reload_value", m_axis_tdata[67:36], want.reload_value);
                check_field("frame_released", m_axis_tdata[68], want.frame_released);
                check_field("padding", m_axis_tdata[71:69], 0);
            end
            results_seen++;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [31:0] stamp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 400)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(compute_event_result(op, stamp));
    endtask

    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN:   cfg_origin   = value[8:0];
            REG_DEBOUNCE: cfg_debounce = value;
            REG_CLOCKS:   cfg_clocks   = value[7:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset configuration: debounce 20000, origin 0, clocks_per_us left at its reset value
    task automatic test_reset_values();
        send_event(OP_PULSE, 32'd100);
        send_event(OP_PULSE, 32'd30000);
        send_event(OP_TICK, 32'h0);
        send_event(OP_FRAME, 32'h0);
        send_event(OP_UNUSED, 32'h0);
        send_event(OP_TICK, 32'h0);
    endtask

    task automatic test_config_extremes();
        wait_drained();
        write_register(REG_DEBOUNCE, 32'd0);
        write_register(REG_CLOCKS, 32'd255);
        write_register(REG_ORIGIN, 32'd383);
        send_event(OP_PULSE, 32'hFFFF_FFFF);
        // equal time stamps: zero elapsed is not above a zero debounce
        send_event(OP_PULSE, 32'hFFFF_FFFF);
        // time stamp wraps to zero
        send_event(OP_PULSE, 32'h0);
        send_event(OP_FRAME, 32'hFFFF_FFFF);
        // angle reaches the resolution: swap but no addresses
        send_event(OP_TICK, 32'h0);
        send_event(OP_TICK, 32'hFFFF_FFFF);
        send_event(OP_FRAME, 32'h0);
        send_event(OP_PULSE, 32'h8000_0000);
        send_event(OP_UNUSED, 32'hFFFF_FFFF);
        wait_drained();
        // origin above the resolution and zero clocks per us
        write_register(REG_ORIGIN, 32'd511);
        write_register(REG_CLOCKS, 32'd0);
        send_event(OP_FRAME, 32'h0);
        send_event(OP_PULSE, 32'h8000_1000);
        send_event(OP_FRAME, 32'h0);
        send_event(OP_TICK, 32'h0);
        wait_drained();
        write_register(REG_DEBOUNCE, 32'hFFFF_FFFF);
        send_event(OP_PULSE, 32'h5555_5555);
        send_event(OP_PULSE, 32'hAAAA_AAAA);
        wait_drained();
        write_register(REG_DEBOUNCE, 32'd0);
        write_register(REG_ORIGIN, 32'd125);
        write_register(REG_CLOCKS, 32'd1);
        send_event(OP_PULSE, 32'h1234_5678);
        send_event(OP_FRAME, 32'h0);
        send_event(OP_TICK, 32'h0);
        send_event(OP_TICK, 32'h0);
        send_event(OP_TICK, 32'h0);
    endtask

    // revolutions: a pulse, a run of ticks with frames mixed in, some noise
    task automatic test_revolutions(input int snd_pct, input int rcv_pct, input int budget);
        int          counted;
        int          ticks;
        int          roll;
        logic [31:0] stamp;
        wait_drained();
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        write_register(REG_ORIGIN, ($urandom_range(7) == 0) ? $urandom_range(511, 384)
                                                            : $urandom_range(383));
        write_register(REG_DEBOUNCE, $urandom_range(4000));
        write_register(REG_CLOCKS, $urandom_range(255, 1));
        stamp   = last_pulse_time;
        counted = 0;
        while (counted < budget)
        begin
            roll = $urandom_range(9);
            if (roll == 0)
            begin
                stamp = stamp + $urandom_range(cfg_debounce);
            end
            else if (roll == 1)
            begin
                stamp = $urandom;
            end
            else
            begin
                stamp = stamp + cfg_debounce + 32'd1 + $urandom_range(60000);
            end
            send_event(OP_PULSE, stamp);
            counted++;
            ticks = ($urandom_range(3) == 0) ? $urandom_range(460) : $urandom_range(150);
            for (int i = 0; i < ticks && counted < budget; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    send_event(OP_FRAME, $urandom);
                    counted++;
                end
                else if (roll == 4)
                begin
                    send_event(OP_UNUSED, $urandom);
                end
                else
                begin
                    send_event(OP_TICK, $urandom);
                    counted++;
                end
            end
        end
    endtask

    // receiver holds off so the block fills, then the sender waits for every result
    task automatic test_backpressure();
        int          roll;
        logic [31:0] stamp;
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_requests++;
        stamp = last_pulse_time;
        for (int i = 0; i < 40; i++)
        begin
            roll = $urandom_range(9);
            if (roll == 0)
            begin
                stamp = stamp + cfg_debounce + 32'd1 + $urandom_range(5000);
                send_event(OP_PULSE, stamp);
            end
            else if (roll == 1)
            begin
                send_event(OP_FRAME, $urandom);
            end
            else
            begin
                send_event(OP_TICK, $urandom);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_config_extremes();
        test_revolutions(18, 88, 400);
        test_revolutions(88, 18, 400);
        test_backpressure();
        test_revolutions(0, 0, 380);
        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("expected results never arrived");
        end
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rdas_pkg.sv
rtl/rotary_display_angle_sequencer_unit.sv
tb/tb.sv
